// ===== hdl/ptam_pkg.sv =====
`default_nettype none

package ptam_pkg;

   // fixed field and register widths
   localparam int TAP_LIST_LEN   = 32;
   localparam int DELAY_WIDTH    = 7;
   localparam int TAP_IDX_WIDTH  = 5;
   localparam int TAP_CNT_WIDTH  = 6;
   localparam int WET_WIDTH      = 17;
   localparam int FRAC_BITS      = 16;
   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int STEP_WIDTH     = 3;

   localparam logic [TAP_CNT_WIDTH-1:0] TAP_COUNT_MIN   = 6'd3;
   localparam logic [TAP_CNT_WIDTH-1:0] TAP_COUNT_MAX   = 6'd32;
   localparam logic [TAP_CNT_WIDTH-1:0] TAP_COUNT_RESET = 6'd3;
   localparam logic [WET_WIDTH-1:0]     WET_ONE         = 17'd65536;
   localparam logic [STEP_WIDTH-1:0]    MULT_STEPS      = 3'd4;

   // register index, taken from paddr[3:2]
   typedef enum logic [1:0] {
      REG_FAT_MODE  = 2'd0,
      REG_WET_GAIN  = 2'd1,
      REG_TAP_COUNT = 2'd2
   } reg_index_type;

   // delay list: 1, then every prime up to 127
   localparam logic [DELAY_WIDTH-1:0] TAP_DELAY [TAP_LIST_LEN] = '{
      7'd1,   7'd2,   7'd3,   7'd5,   7'd7,   7'd11,  7'd13,  7'd17,
      7'd19,  7'd23,  7'd29,  7'd31,  7'd37,  7'd41,  7'd43,  7'd47,
      7'd53,  7'd59,  7'd61,  7'd67,  7'd71,  7'd73,  7'd79,  7'd83,
      7'd89,  7'd97,  7'd101, 7'd103, 7'd107, 7'd109, 7'd113, 7'd127
   };

   // sequencer states
   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_READ   = 5'b00010,
      ST_DIVIDE = 5'b00100,
      ST_MULT   = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

endpackage

`default_nettype wire

// ===== hdl/prime_tap_average_mixer_core.sv =====
`default_nettype none

// channel  | direction | ports                               | handshake
// req      | in        | req_left_sample, req_right_sample   | req_valid / req_ready
// rsp      | out       | rsp_left_out, rsp_right_out         | rsp_valid / rsp_ready
// csr      | in/out    | csr_paddr, csr_pwdata, csr_prdata   | csr_psel / csr_penable / csr_pready
//
// the time from one req transfer to the next is set by the single history read port
// (one tap per cycle), the one-bit-per-cycle divider and the mix steps; rsp_valid rises
// when the finished result is loaded into the output register.
// req_ready is high only while the sequencer is idle; a finished result waits in the
// output register, so the next frame may be taken while rsp_valid is stalled.
// reset is synchronous; history entries not yet written since reset read as zero.

module prime_tap_average_mixer_core #(
   parameter int HISTORY_DEPTH = 128,
   parameter int SAMPLE_WIDTH  = 24
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic signed [SAMPLE_WIDTH-1:0]        req_left_sample,
   input  wire logic signed [SAMPLE_WIDTH-1:0]        req_right_sample,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0]             rsp_left_out,
   output logic signed [SAMPLE_WIDTH-1:0]             rsp_right_out,
   input  wire logic                                  csr_psel,
   input  wire logic                                  csr_penable,
   input  wire logic                                  csr_pwrite,
   input  wire logic [ptam_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  wire logic [ptam_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic [ptam_pkg::CSR_DATA_WIDTH-1:0]        csr_prdata,
   output logic                                       csr_pready
);

   localparam int ADDR_W = $clog2(HISTORY_DEPTH);
   localparam int SUM_W  = SAMPLE_WIDTH + 6;
   localparam int MAG_W  = SAMPLE_WIDTH + 5;
   localparam int GAIN_W = ptam_pkg::WET_WIDTH + 1;
   localparam int PROD_W = SUM_W + GAIN_W;
   localparam int ACC_W  = SAMPLE_WIDTH + 8;
   localparam int TCW    = ptam_pkg::TAP_CNT_WIDTH;
   localparam int WW     = ptam_pkg::WET_WIDTH;

   localparam logic signed [ACC_W-1:0] OUT_MAX = ACC_W'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
   localparam logic signed [ACC_W-1:0] OUT_MIN = -OUT_MAX - ACC_W'(1);

   ptam_pkg::state_type state_ff, state_in;

   // configuration registers
   logic            fat_mode_ff, fat_mode_in;
   logic [WW-1:0]   wet_gain_ff, wet_gain_in;
   logic [TCW-1:0]  tap_count_ff, tap_count_in;

   // history bookkeeping
   logic [ADDR_W-1:0]        wp_ff, wp_in;
   logic [HISTORY_DEPTH-1:0] valid_ff, valid_in;

   // frame operands
   logic signed [SAMPLE_WIDTH-1:0] x_left_ff, x_right_ff;
   logic [TCW-1:0]                 taps_ff;
   logic [WW-1:0]                  wet_ff;
   logic                           fat_ff;

   // tap read loop
   logic [TCW-1:0]          issue_ff, issue_in;
   logic                    pend_ff, pend_in;
   logic                    rd_valid_ff, rd_valid_in;
   logic signed [SUM_W-1:0] sum_left_ff, sum_left_in;
   logic signed [SUM_W-1:0] sum_right_ff, sum_right_in;

   // mix loop
   logic signed [SUM_W-1:0]  avg_left_ff, avg_right_ff;
   logic [ptam_pkg::STEP_WIDTH-1:0] step_ff, step_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     prod_pend_ff, prod_pend_in;
   logic [1:0]               prod_sel_ff, prod_sel_in;
   logic signed [ACC_W-1:0]  acc_left_ff, acc_left_in;
   logic signed [ACC_W-1:0]  acc_right_ff, acc_right_in;

   // output register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_left_ff, rsp_right_ff;

   logic                   req_xfer;
   logic                   csr_write;
   logic [TCW-1:0]         taps_clamped;
   logic [WW-1:0]          wet_clamped;
   logic                   issue;
   logic [ptam_pkg::DELAY_WIDTH-1:0] delay;
   logic [ADDR_W:0]        wp_ext, delay_ext;
   logic [ADDR_W-1:0]      rd_addr;
   logic [2*SAMPLE_WIDTH-1:0] rd_data;
   logic signed [SUM_W-1:0] tap_left, tap_right;
   logic                   div_start, div_done;
   logic signed [SUM_W-1:0] quo_left, quo_right;
   logic signed [SUM_W-1:0] mul_a;
   logic signed [GAIN_W-1:0] mul_b;
   logic [WW-1:0]          dry_gain;
   logic signed [PROD_W-1:0] prod_shift;
   logic signed [ACC_W-1:0] term;
   logic signed [SAMPLE_WIDTH-1:0] sat_left, sat_right;
   logic                   out_load;

   assign req_xfer  = req_valid && req_ready;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign req_ready = (state_ff == ptam_pkg::ST_IDLE);

   // configuration write and readback
   always_comb begin
      fat_mode_in  = fat_mode_ff;
      wet_gain_in  = wet_gain_ff;
      tap_count_in = tap_count_ff;
      csr_prdata   = '0;
      case (ptam_pkg::reg_index_type'(csr_paddr[3:2]))
         ptam_pkg::REG_FAT_MODE: begin
            csr_prdata = ptam_pkg::CSR_DATA_WIDTH'(fat_mode_ff);
            if (csr_write) fat_mode_in = csr_pwdata[0];
         end
         ptam_pkg::REG_WET_GAIN: begin
            csr_prdata = ptam_pkg::CSR_DATA_WIDTH'(wet_gain_ff);
            if (csr_write) wet_gain_in = csr_pwdata[WW-1:0];
         end
         ptam_pkg::REG_TAP_COUNT: begin
            csr_prdata = ptam_pkg::CSR_DATA_WIDTH'(tap_count_ff);
            if (csr_write) tap_count_in = csr_pwdata[TCW-1:0];
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   assign csr_pready = 1'b1;

   // clamp settings when a frame is taken
   always_comb begin
      if (tap_count_ff < ptam_pkg::TAP_COUNT_MIN) begin
         taps_clamped = ptam_pkg::TAP_COUNT_MIN;
      end else if (tap_count_ff > ptam_pkg::TAP_COUNT_MAX) begin
         taps_clamped = ptam_pkg::TAP_COUNT_MAX;
      end else begin
         taps_clamped = tap_count_ff;
      end
      wet_clamped = (wet_gain_ff > ptam_pkg::WET_ONE) ? ptam_pkg::WET_ONE : wet_gain_ff;
   end

   // tap address: write pointer minus delay, wrapped
   assign issue     = (state_ff == ptam_pkg::ST_READ) && (issue_ff < taps_ff);
   assign delay     = ptam_pkg::TAP_DELAY[issue_ff[ptam_pkg::TAP_IDX_WIDTH-1:0]];
   assign wp_ext    = {1'b0, wp_ff};
   assign delay_ext = (ADDR_W+1)'(delay);
   always_comb begin
      if (wp_ext >= delay_ext) begin
         rd_addr = ADDR_W'(wp_ext - delay_ext);
      end else begin
         rd_addr = ADDR_W'(wp_ext + (ADDR_W+1)'(HISTORY_DEPTH) - delay_ext);
      end
   end

   ptam_ram #(
      .WIDTH (2*SAMPLE_WIDTH),
      .DEPTH (HISTORY_DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (req_xfer),
      .wr_addr (wp_ff),
      .wr_data ({req_left_sample, req_right_sample}),
      .rd_en   (issue),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // entries never written since reset count as zero
   assign tap_left  = rd_valid_ff ? SUM_W'($signed(rd_data[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]))
                                  : '0;
   assign tap_right = rd_valid_ff ? SUM_W'($signed(rd_data[SAMPLE_WIDTH-1:0])) : '0;

   assign div_start = (state_ff == ptam_pkg::ST_READ) && !issue && !pend_ff;

   ptam_div #(
      .MAG_WIDTH (MAG_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .num_left  (sum_left_ff),
      .num_right (sum_right_ff),
      .den       (taps_ff),
      .done      (div_done),
      .quo_left  (quo_left),
      .quo_right (quo_right)
   );

   // shared multiplier operands: even steps wet*avg, odd steps x*dry
   assign dry_gain = fat_ff ? WW'(ptam_pkg::WET_ONE - wet_ff) : '0;
   always_comb begin
      if (step_ff[0]) begin
         mul_a = step_ff[1] ? SUM_W'(x_right_ff) : SUM_W'(x_left_ff);
         mul_b = $signed({1'b0, dry_gain});
      end else begin
         mul_a = step_ff[1] ? avg_right_ff : avg_left_ff;
         mul_b = $signed({1'b0, wet_ff});
      end
   end

   // registered product, floor shift, signed term for the accumulator
   assign prod_shift = prod_ff >>> ptam_pkg::FRAC_BITS;
   always_comb begin
      term = ACC_W'(prod_shift);
      if (!prod_sel_ff[0] && !fat_ff) begin
         term = -ACC_W'(prod_shift);
      end
   end

   // saturate to the sample width
   always_comb begin
      if (acc_left_ff > OUT_MAX) begin
         sat_left = SAMPLE_WIDTH'(OUT_MAX);
      end else if (acc_left_ff < OUT_MIN) begin
         sat_left = SAMPLE_WIDTH'(OUT_MIN);
      end else begin
         sat_left = SAMPLE_WIDTH'(acc_left_ff);
      end
      if (acc_right_ff > OUT_MAX) begin
         sat_right = SAMPLE_WIDTH'(OUT_MAX);
      end else if (acc_right_ff < OUT_MIN) begin
         sat_right = SAMPLE_WIDTH'(OUT_MIN);
      end else begin
         sat_right = SAMPLE_WIDTH'(acc_right_ff);
      end
   end

   assign out_load = (state_ff == ptam_pkg::ST_FINISH) && (!rsp_valid_ff || rsp_ready);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      valid_in     = valid_ff;
      issue_in     = issue_ff;
      pend_in      = 1'b0;
      rd_valid_in  = valid_ff[rd_addr];
      sum_left_in  = sum_left_ff;
      sum_right_in = sum_right_ff;
      step_in      = step_ff;
      prod_in      = mul_a * mul_b;
      prod_pend_in = 1'b0;
      prod_sel_in  = step_ff[1:0];
      acc_left_in  = acc_left_ff;
      acc_right_in = acc_right_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ptam_pkg::ST_IDLE: begin
            if (req_xfer) begin
               valid_in[wp_ff] = 1'b1;
               issue_in        = '0;
               sum_left_in     = SUM_W'(req_left_sample);
               sum_right_in    = SUM_W'(req_right_sample);
               state_in        = ptam_pkg::ST_READ;
            end
         end
         ptam_pkg::ST_READ: begin
            // one tap read a cycle, added in the next cycle
            if (issue) begin
               issue_in = issue_ff + 1'b1;
               pend_in  = 1'b1;
            end
            if (pend_ff) begin
               sum_left_in  = sum_left_ff + tap_left;
               sum_right_in = sum_right_ff + tap_right;
            end
            if (div_start) begin
               state_in = ptam_pkg::ST_DIVIDE;
            end
         end
         ptam_pkg::ST_DIVIDE: begin
            if (div_done) begin
               step_in      = '0;
               acc_left_in  = fat_ff ? '0 : ACC_W'(x_left_ff);
               acc_right_in = fat_ff ? '0 : ACC_W'(x_right_ff);
               state_in     = ptam_pkg::ST_MULT;
            end
         end
         ptam_pkg::ST_MULT: begin
            if (step_ff != ptam_pkg::MULT_STEPS) begin
               step_in      = step_ff + 1'b1;
               prod_pend_in = 1'b1;
            end
            if (prod_pend_ff) begin
               if (prod_sel_ff[1]) begin
                  acc_right_in = acc_right_ff + term;
               end else begin
                  acc_left_in = acc_left_ff + term;
               end
            end
            if (step_ff == ptam_pkg::MULT_STEPS && !prod_pend_ff) begin
               state_in = ptam_pkg::ST_FINISH;
            end
         end
         ptam_pkg::ST_FINISH: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               wp_in        = (wp_ff == ADDR_W'(HISTORY_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
               state_in     = ptam_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ptam_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ptam_pkg::ST_IDLE;
         fat_mode_ff  <= 1'b1;
         wet_gain_ff  <= '0;
         tap_count_ff <= ptam_pkg::TAP_COUNT_RESET;
         wp_ff        <= '0;
         valid_ff     <= '0;
         pend_ff      <= 1'b0;
         prod_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fat_mode_ff  <= fat_mode_in;
         wet_gain_ff  <= wet_gain_in;
         tap_count_ff <= tap_count_in;
         wp_ff        <= wp_in;
         valid_ff     <= valid_in;
         pend_ff      <= pend_in;
         prod_pend_ff <= prod_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         x_left_ff  <= req_left_sample;
         x_right_ff <= req_right_sample;
         taps_ff    <= taps_clamped;
         wet_ff     <= wet_clamped;
         fat_ff     <= fat_mode_ff;
      end
      if (div_done) begin
         avg_left_ff  <= quo_left + SUM_W'(1);
         avg_right_ff <= quo_right + SUM_W'(1);
      end
      if (out_load) begin
         rsp_left_ff  <= sat_left;
         rsp_right_ff <= sat_right;
      end
      issue_ff     <= issue_in;
      rd_valid_ff  <= rd_valid_in;
      sum_left_ff  <= sum_left_in;
      sum_right_ff <= sum_right_in;
      step_ff      <= step_in;
      prod_ff      <= prod_in;
      prod_sel_ff  <= prod_sel_in;
      acc_left_ff  <= acc_left_in;
      acc_right_ff <= acc_right_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = rsp_left_ff;
   assign rsp_right_out = rsp_right_ff;

endmodule

`default_nettype wire

// ===== hdl/ptam_ram.sv =====
`default_nettype none

module ptam_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/ptam_div.sv =====
`default_nettype none

module ptam_div #(
   parameter int MAG_WIDTH = 29
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   input  wire logic signed [MAG_WIDTH:0]              num_left,
   input  wire logic signed [MAG_WIDTH:0]              num_right,
   input  wire logic [ptam_pkg::TAP_CNT_WIDTH-1:0]     den,
   output logic                                        done,
   output logic signed [MAG_WIDTH:0]                   quo_left,
   output logic signed [MAG_WIDTH:0]                   quo_right
);

   localparam int CNT_WIDTH = $clog2(MAG_WIDTH);
   localparam int REM_WIDTH = ptam_pkg::TAP_CNT_WIDTH;

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [CNT_WIDTH-1:0]        cnt_ff, cnt_in;
   logic [REM_WIDTH-1:0]        den_ff, den_in;
   logic [1:0]                  neg_ff, neg_in;
   logic [MAG_WIDTH-1:0]        dvd_ff [2];
   logic [MAG_WIDTH-1:0]        dvd_in [2];
   logic [REM_WIDTH-1:0]        rem_ff [2];
   logic [REM_WIDTH-1:0]        rem_in [2];
   logic signed [MAG_WIDTH:0]   num    [2];
   logic [MAG_WIDTH:0]          mag    [2];
   logic [REM_WIDTH:0]          trial  [2];
   logic signed [MAG_WIDTH:0]   quo    [2];

   assign num[0] = num_left;
   assign num[1] = num_right;

   // restoring divide, one quotient bit per cycle in each lane
   // the dividend register fills up with quotient bits from the bottom
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      for (int i = 0; i < 2; i++) begin
         mag[i]   = num[i][MAG_WIDTH] ? (MAG_WIDTH+1)'(-num[i]) : num[i];
         trial[i] = {rem_ff[i], dvd_ff[i][MAG_WIDTH-1]};
         dvd_in[i] = dvd_ff[i];
         rem_in[i] = rem_ff[i];
      end
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_WIDTH'(MAG_WIDTH - 1);
         den_in  = den;
         for (int i = 0; i < 2; i++) begin
            neg_in[i] = num[i][MAG_WIDTH];
            dvd_in[i] = mag[i][MAG_WIDTH-1:0];
            rem_in[i] = '0;
         end
      end else if (busy_ff) begin
         for (int i = 0; i < 2; i++) begin
            if (trial[i] >= {1'b0, den_ff}) begin
               rem_in[i] = REM_WIDTH'(trial[i] - {1'b0, den_ff});
               dvd_in[i] = {dvd_ff[i][MAG_WIDTH-2:0], 1'b1};
            end else begin
               rem_in[i] = trial[i][REM_WIDTH-1:0];
               dvd_in[i] = {dvd_ff[i][MAG_WIDTH-2:0], 1'b0};
            end
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      for (int i = 0; i < 2; i++) begin
         dvd_ff[i] <= dvd_in[i];
         rem_ff[i] <= rem_in[i];
      end
   end

   // quotient sign follows the dividend, truncating toward zero
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         quo[i] = neg_ff[i] ? -$signed({1'b0, dvd_ff[i]}) : $signed({1'b0, dvd_ff[i]});
      end
   end

   assign done      = done_ff;
   assign quo_left  = quo[0];
   assign quo_right = quo[1];

endmodule

`default_nettype wire

// ===== hdl/ptam_checker.sv =====
`default_nettype none

module ptam_checker #(
   parameter int SAMPLE_WIDTH = 24
) (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_ready,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_ready,
   input wire logic [SAMPLE_WIDTH-1:0]             rsp_left_out,
   input wire logic [SAMPLE_WIDTH-1:0]             rsp_right_out
);

   // reset leaves no result pending and the block ready
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("result pending or block busy after reset");

   // a stalled result holds its data
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !reset && rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_left_out) && $stable(rsp_right_out))
      else $error("stalled result changed");

   // a taken frame keeps the block busy for at least the next cycle
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      !reset && req_valid && req_ready |=> !req_ready)
      else $error("block ready right after taking a frame");

   // a new result only comes out of a busy sequencer
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared while idle");

endmodule

bind prime_tap_average_mixer_core ptam_checker #(
   .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_ptam_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_left_out     (rsp_left_out),
   .rsp_right_out    (rsp_right_out)
);

`default_nettype wire
